@@ src/frs_pkg.sv @@
// Package with shared constants, phase encoding and item types of the FASTA record scanner.
package frs_pkg;

  localparam int FRS_LENGTH_BITS = 32;
  localparam int FRS_OUT_LEN_BITS = 32;

  localparam logic [7:0] CH_HEADER = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [0:0] {
    KIND_ID = 1'b0,
    KIND_RECORD = 1'b1
  } frs_kind_t;

  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_SKIPSP = 3'd1,
    PH_ID = 3'd2,
    PH_RESTLINE = 3'd3,
    PH_BODY = 3'd4
  } frs_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic end_of_data;
  } frs_item_t;

  typedef struct packed {
    frs_kind_t result_kind;
    logic [7:0] id_byte;
    logic [FRS_OUT_LEN_BITS-1:0] record_length;
    logic length_saturated;
    logic final_record;
  } frs_result_t;

endpackage

@@ src/frs_if.sv @@
// Valid/ready channel interfaces for the input bytes and the results.
interface frs_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface frs_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic [7:0] id_byte;
  logic [31:0] record_length;
  logic length_saturated;
  logic final_record;

  modport source (output valid, output result_kind, output id_byte, output record_length,
                  output length_saturated, output final_record, input ready);
  modport sink (input valid, input result_kind, input id_byte, input record_length,
                input length_saturated, input final_record, output ready);
endinterface

@@ src/frs_in_stage.sv @@
// Input register that holds one accepted byte until the parser consumes it.
module frs_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frs_pkg::frs_item_t  in_item,
  input  logic                take,
  output logic                item_valid,
  output frs_pkg::frs_item_t  item
);

  logic               valid_r;
  logic               valid_nxt;
  frs_pkg::frs_item_t item_r;

  assign in_ready = !valid_r || take;
  assign item_valid = valid_r;
  assign item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ src/frs_parser.sv @@
// Scan phase tracking, letter counter and result formation for one byte.
module frs_parser #(
  parameter int LENGTH_BITS = frs_pkg::FRS_LENGTH_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  frs_pkg::frs_item_t   item,
  input  logic                 commit,
  output logic                 res_valid,
  output frs_pkg::frs_result_t res
);

  localparam int OB = frs_pkg::FRS_OUT_LEN_BITS;

  frs_pkg::frs_phase_t    phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic                   full_r, full_nxt;

  logic [LENGTH_BITS-1:0] count_upd;
  logic                   full_upd;
  logic                   is_body;
  logic                   is_letter;
  logic                   in_rec;
  logic                   emit_id;
  logic                   emit_rec;
  logic [OB-1:0]          rec_len;
  logic                   rec_sat;

  assign is_body = (phase_r != frs_pkg::PH_SEEK) && (phase_r != frs_pkg::PH_SKIPSP) &&
                   (phase_r != frs_pkg::PH_ID) && (phase_r != frs_pkg::PH_RESTLINE);
  assign is_letter = (item.data_byte inside {[frs_pkg::CH_UPPER_A:frs_pkg::CH_UPPER_Z],
                                             [frs_pkg::CH_LOWER_A:frs_pkg::CH_LOWER_Z]});

  always_comb begin
    count_upd = count_r;
    full_upd = full_r;
    if (is_body && is_letter) begin
      if (!(&count_r)) begin
        count_upd = count_r + 1'b1;
      end
      if (&count_upd) begin
        full_upd = 1'b1;
      end
    end
  end

  generate
    if (LENGTH_BITS > OB) begin : g_clamp
      logic high_set;
      assign high_set = |count_upd[LENGTH_BITS-1:OB];
      assign rec_len = high_set ? {OB{1'b1}} : count_upd[OB-1:0];
      assign rec_sat = full_upd || high_set;
    end else begin : g_direct
      assign rec_len = OB'(count_upd);
      assign rec_sat = full_upd;
    end
  endgenerate

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_upd;
    full_nxt = full_upd;
    emit_id = 1'b0;
    emit_rec = 1'b0;
    in_rec = (phase_r != frs_pkg::PH_SEEK);
    case (phase_r)
      frs_pkg::PH_SEEK: begin
        if (item.data_byte == frs_pkg::CH_HEADER) begin
          phase_nxt = frs_pkg::PH_SKIPSP;
          in_rec = 1'b1;
        end
      end
      frs_pkg::PH_SKIPSP, frs_pkg::PH_ID: begin
        if (item.data_byte == frs_pkg::CH_NEWLINE) begin
          phase_nxt = frs_pkg::PH_BODY;
        end else if (item.data_byte == frs_pkg::CH_SPACE) begin
          if (phase_r == frs_pkg::PH_ID) begin
            phase_nxt = frs_pkg::PH_RESTLINE;
          end
        end else begin
          phase_nxt = frs_pkg::PH_ID;
          emit_id = !item.end_of_data;
        end
      end
      frs_pkg::PH_RESTLINE: begin
        if (item.data_byte == frs_pkg::CH_NEWLINE) begin
          phase_nxt = frs_pkg::PH_BODY;
        end
      end
      default: begin
        phase_nxt = frs_pkg::PH_BODY;
        if (item.data_byte == frs_pkg::CH_HEADER) begin
          emit_rec = 1'b1;
          phase_nxt = frs_pkg::PH_SKIPSP;
          count_nxt = '0;
          full_nxt = 1'b0;
        end
      end
    endcase
    if (item.end_of_data) begin
      if (in_rec) begin
        emit_rec = 1'b1;
        emit_id = 1'b0;
      end
      phase_nxt = frs_pkg::PH_SEEK;
      count_nxt = '0;
      full_nxt = 1'b0;
    end
  end

  always_comb begin
    res_valid = emit_id || emit_rec;
    res = '0;
    if (emit_rec) begin
      res.result_kind = frs_pkg::KIND_RECORD;
      res.record_length = rec_len;
      res.length_saturated = rec_sat;
      res.final_record = item.end_of_data;
    end else begin
      res.result_kind = frs_pkg::KIND_ID;
      res.id_byte = item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= frs_pkg::PH_SEEK;
      count_r <= '0;
      full_r <= 1'b0;
    end else if (commit) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      full_r <= full_nxt;
    end
  end

endmodule

@@ src/frs_out_stage.sv @@
// Result register that holds one result until the receiver takes it.
module frs_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  frs_pkg::frs_result_t res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output frs_pkg::frs_result_t out_res
);

  logic                 valid_r;
  logic                 valid_nxt;
  frs_pkg::frs_result_t res_r;

  assign free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res;
    end
  end

endmodule

@@ src/fasta_record_scanner.sv @@
// Top level of the FASTA record scanner: input register, parser and result register.
// The scanner reads FASTA text one byte per transfer on in_chan, with end_of_data
// set on the last byte of the text. Bytes ahead of the first '>' are ignored.
// Each identifier byte of a header, but one that carries end_of_data, leaves as
// one transfer on out_chan with result_kind 0; each closed record leaves as one
// transfer with result_kind 1, carrying its body's letter count, a saturation
// flag and a flag that tells whether the record was closed by the end of the data.
// A result passes from the input register through the parser into the result
// register before it is valid on out_chan.
// The scanner takes one byte per cycle unless a byte that yields a result waits
// for the result register; the parser updates its phase and counter in between.
// When the receiver stalls, the held result stays on out_chan; a byte that
// yields no result still passes through, and the input register fills and
// drops in_chan.ready only once a byte that yields a result must wait.
// Synchronous reset clears both registers' valid flags and returns the parser
// to the state of seeking a header marker with a zero count; no transfer is
// lost or repeated across a stall.
module fasta_record_scanner #(
  parameter int LENGTH_BITS = frs_pkg::FRS_LENGTH_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  frs_in_if.sink    in_chan,
  frs_out_if.source out_chan
);

  frs_pkg::frs_item_t   in_item;
  frs_pkg::frs_item_t   item;
  frs_pkg::frs_result_t res;
  frs_pkg::frs_result_t out_res;
  logic                 item_valid;
  logic                 res_valid;
  logic                 take;
  logic                 out_free;

  assign in_item.data_byte = in_chan.data_byte;
  assign in_item.end_of_data = in_chan.end_of_data;
  assign take = item_valid && (out_free || !res_valid);

  frs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  frs_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .commit    (take),
    .res_valid (res_valid),
    .res       (res)
  );

  frs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.result_kind = out_res.result_kind;
  assign out_chan.id_byte = out_res.id_byte;
  assign out_chan.record_length = out_res.record_length;
  assign out_chan.length_saturated = out_res.length_saturated;
  assign out_chan.final_record = out_res.final_record;

endmodule

@@ sim/frs_scan_checker.sv @@
// Checker that predicts the scanner's results from its input transfers and compares them.
module frs_scan_checker #(
  parameter int LENGTH_BITS = frs_pkg::FRS_LENGTH_BITS
) (
  input  logic clk,
  input  logic rst_n,
  frs_in_if    in_mon,
  frs_out_if   out_mon,
  output int   mismatch_count,
  output int   results_owed
);

  localparam logic [63:0] COUNT_LIMIT = (LENGTH_BITS >= 64) ? {64{1'b1}} :
                                        ((64'd1 << LENGTH_BITS) - 64'd1);

  frs_pkg::frs_phase_t  scan_phase;
  logic [63:0]          letter_total;
  logic                 letters_full;
  frs_pkg::frs_result_t expected_results[$];

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("mismatch at %0t: %s, expected %0h, got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  task automatic clear_scan();
    scan_phase = frs_pkg::PH_SEEK;
    letter_total = '0;
    letters_full = 1'b0;
  endtask

  task automatic expect_record(input logic closed_by_end);
    frs_pkg::frs_result_t rec;
    rec = '0;
    rec.result_kind = frs_pkg::KIND_RECORD;
    rec.length_saturated = letters_full;
    if (letter_total > 64'hFFFF_FFFF) begin
      rec.record_length = 32'hFFFF_FFFF;
      rec.length_saturated = 1'b1;
    end else begin
      rec.record_length = letter_total[31:0];
    end
    rec.final_record = closed_by_end;
    expected_results.push_back(rec);
    letter_total = '0;
    letters_full = 1'b0;
  endtask

  task automatic expect_id(input logic [7:0] b);
    frs_pkg::frs_result_t idr;
    idr = '0;
    idr.result_kind = frs_pkg::KIND_ID;
    idr.id_byte = b;
    expected_results.push_back(idr);
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic open_record;
    open_record = (scan_phase != frs_pkg::PH_SEEK);
    case (scan_phase)
      frs_pkg::PH_SEEK: begin
        if (b == frs_pkg::CH_HEADER) begin
          scan_phase = frs_pkg::PH_SKIPSP;
          open_record = 1'b1;
        end
      end
      frs_pkg::PH_SKIPSP, frs_pkg::PH_ID: begin
        if (b == frs_pkg::CH_NEWLINE) begin
          scan_phase = frs_pkg::PH_BODY;
        end else if (b == frs_pkg::CH_SPACE) begin
          if (scan_phase == frs_pkg::PH_ID) scan_phase = frs_pkg::PH_RESTLINE;
        end else begin
          scan_phase = frs_pkg::PH_ID;
          if (!last) expect_id(b);
        end
      end
      frs_pkg::PH_RESTLINE: begin
        if (b == frs_pkg::CH_NEWLINE) scan_phase = frs_pkg::PH_BODY;
      end
      default: begin
        scan_phase = frs_pkg::PH_BODY;
        if (b == frs_pkg::CH_HEADER) begin
          expect_record(last);
          scan_phase = frs_pkg::PH_SKIPSP;
          if (last) begin
            clear_scan();
            return;
          end
        end else if ((b >= frs_pkg::CH_UPPER_A && b <= frs_pkg::CH_UPPER_Z) ||
                     (b >= frs_pkg::CH_LOWER_A && b <= frs_pkg::CH_LOWER_Z)) begin
          if (letter_total < COUNT_LIMIT) letter_total++;
          if (letter_total >= COUNT_LIMIT) letters_full = 1'b1;
        end
      end
    endcase
    if (last) begin
      if (open_record) expect_record(1'b1);
      clear_scan();
    end
  endtask

  task automatic check_result();
    frs_pkg::frs_result_t want;
    frs_pkg::frs_result_t got;
    got.result_kind = frs_pkg::frs_kind_t'(out_mon.result_kind);
    got.id_byte = out_mon.id_byte;
    got.record_length = out_mon.record_length;
    got.length_saturated = out_mon.length_saturated;
    got.final_record = out_mon.final_record;
    if (expected_results.size() == 0) begin
      note_mismatch("result with nothing expected", '0, 64'(got));
    end else begin
      want = expected_results.pop_front();
      if (got.result_kind != want.result_kind)
        note_mismatch("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      if (got.id_byte != want.id_byte)
        note_mismatch("id_byte", 64'(want.id_byte), 64'(got.id_byte));
      if (got.record_length != want.record_length)
        note_mismatch("record_length", 64'(want.record_length), 64'(got.record_length));
      if (got.length_saturated != want.length_saturated)
        note_mismatch("length_saturated", 64'(want.length_saturated),
                      64'(got.length_saturated));
      if (got.final_record != want.final_record)
        note_mismatch("final_record", 64'(want.final_record), 64'(got.final_record));
    end
  endtask

  initial begin
    mismatch_count = 0;
    results_owed = 0;
    clear_scan();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) scan_byte(in_mon.data_byte, in_mon.end_of_data);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    results_owed = expected_results.size();
  end

endmodule

@@ sim/tb_fasta_record_scanner.sv @@
// Testbench top that feeds FASTA text to the scanner, stalls both sides and gives the verdict.
module tb_fasta_record_scanner;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int OPENING_LEN = 26;

  localparam frs_pkg::frs_item_t OPENING_TEXT [OPENING_LEN] = '{
    '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{frs_pkg::CH_HEADER, 1'b0},
    '{frs_pkg::CH_SPACE, 1'b0}, '{8'hFF, 1'b0}, '{frs_pkg::CH_HEADER, 1'b0},
    '{frs_pkg::CH_SPACE, 1'b0}, '{8'h71, 1'b0}, '{frs_pkg::CH_NEWLINE, 1'b0},
    '{frs_pkg::CH_UPPER_A, 1'b0}, '{frs_pkg::CH_LOWER_Z, 1'b0},
    '{frs_pkg::CH_UPPER_Z, 1'b0}, '{frs_pkg::CH_LOWER_A, 1'b0},
    '{frs_pkg::CH_UPPER_A - 8'd1, 1'b0}, '{frs_pkg::CH_UPPER_Z + 8'd1, 1'b0},
    '{frs_pkg::CH_LOWER_A - 8'd1, 1'b0}, '{frs_pkg::CH_LOWER_Z + 8'd1, 1'b0},
    '{frs_pkg::CH_HEADER, 1'b0}, '{frs_pkg::CH_NEWLINE, 1'b0}, '{8'h67, 1'b0},
    '{frs_pkg::CH_HEADER, 1'b1}, '{8'h78, 1'b1}, '{frs_pkg::CH_HEADER, 1'b0},
    '{8'h6B, 1'b1}, '{frs_pkg::CH_HEADER, 1'b0}, '{frs_pkg::CH_SPACE, 1'b1}
  };

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   results_owed;
  int   bytes_sent;
  int   cycle_count;
  int   sender_idle_pct;
  int   receiver_idle_pct;

  frs_in_if  byte_chan ();
  frs_out_if result_chan ();

  fasta_record_scanner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (byte_chan),
    .out_chan (result_chan)
  );

  frs_scan_checker checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (byte_chan),
    .out_mon        (result_chan),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    result_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_chan.valid <= 1'b0;
      @(posedge clk);
    end
    byte_chan.valid <= 1'b1;
    byte_chan.data_byte <= b;
    byte_chan.end_of_data <= last;
    @(posedge clk);
    while (!byte_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic hold_until_drained();
    byte_chan.valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] id_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == frs_pkg::CH_SPACE || b == frs_pkg::CH_NEWLINE);
    return b;
  endfunction

  function automatic logic [7:0] line_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == frs_pkg::CH_NEWLINE);
    return b;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] b;
    if ($urandom_range(9) < 7) begin
      b = frs_pkg::CH_UPPER_A + 8'($urandom_range(25));
      if ($urandom_range(1)) b = b + (frs_pkg::CH_LOWER_A - frs_pkg::CH_UPPER_A);
    end else begin
      do b = 8'($urandom_range(255)); while (b == frs_pkg::CH_HEADER);
    end
    return b;
  endfunction

  task automatic send_random_record();
    logic [7:0] text[$];
    int cut;
    int i;
    text.push_back(frs_pkg::CH_HEADER);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(frs_pkg::CH_SPACE);
    end
    repeat ($urandom_range(0, 6)) text.push_back(id_char());
    if ($urandom_range(1)) begin
      text.push_back(frs_pkg::CH_SPACE);
      repeat ($urandom_range(0, 5)) text.push_back(line_char());
    end
    text.push_back(frs_pkg::CH_NEWLINE);
    repeat ($urandom_range(0, 40)) text.push_back(body_char());
    cut = ($urandom_range(9) == 0) ? $urandom_range(0, text.size() - 1) : text.size();
    for (i = 0; i < text.size() && i <= cut; i++) begin
      push_byte(text[i], i == cut);
    end
  endtask

  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(255)), (i == n - 1) && ($urandom_range(3) == 0));
    end
  endtask

  task automatic run_random_text(input int byte_goal);
    while (bytes_sent < byte_goal) begin
      if ($urandom_range(7) == 0) begin
        send_noise();
      end else begin
        send_random_record();
      end
    end
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    bytes_sent = 0;
    sender_idle_pct = 20;
    receiver_idle_pct = 66;
    byte_chan.valid = 1'b0;
    byte_chan.data_byte = '0;
    byte_chan.end_of_data = 1'b0;
    result_chan.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < OPENING_LEN; k++) begin
      push_byte(OPENING_TEXT[k].data_byte, OPENING_TEXT[k].end_of_data);
    end
    hold_until_drained();

    run_random_text(225);
    hold_until_drained();
    sender_idle_pct = 66;
    receiver_idle_pct = 20;
    run_random_text(425);
    hold_until_drained();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    run_random_text(625);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
